// ----- hw/rtl/max_pool_2d_argmax_macros.svh -----
// ----------------------------------------------------------------------------
// max_pool_2d_argmax_macros.svh
// Assertion macros used by the checker file of the pooling block.
// ----------------------------------------------------------------------------
`ifndef MAX_POOL_2D_ARGMAX_MACROS_SVH
`define MAX_POOL_2D_ARGMAX_MACROS_SVH

// Next-cycle implication, masked while reset is asserted.
`define MP2A_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("max_pool_2d_argmax: check failed");

// Same-cycle implication, masked while reset is asserted.
`define MP2A_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("max_pool_2d_argmax: check failed");

// Next-cycle implication that also holds across reset.
`define MP2A_ASSERT_RST(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) (pre) |=> (post)) \
        else $error("max_pool_2d_argmax: reset check failed");

`endif

// ----- hw/rtl/mp2a_pkg.sv -----
// ----------------------------------------------------------------------------
// mp2a_pkg
// Shared constants, register indexes and controller/datapath types.
// ----------------------------------------------------------------------------
`default_nettype none

package mp2a_pkg;

    localparam int MAX_ROWS     = 64;
    localparam int MAX_COLS     = 64;
    localparam int MAX_KERNEL   = 8;   // power of two: line store row select is a bit slice
    localparam int SAMPLE_WIDTH = 16;

    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int LSEL_W   = $clog2(MAX_KERNEL);
    localparam int KIDX_W   = $clog2(MAX_KERNEL);
    localparam int STORE_DEPTH = MAX_KERNEL * MAX_COLS;
    localparam int STORE_AW = $clog2(STORE_DEPTH);

    // Register field widths
    localparam int DIM_W   = 7;
    localparam int KDIM_W  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam int INDEX_W = 12;
    localparam int IMG_W   = 16;
    localparam int PROD_W  = ROW_W + DIM_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IN_ROWS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_COLS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROWS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COLS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_ROW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_COL  = 3'd5;

    // Register reset values
    localparam logic [DIM_W-1:0]  RST_IN_DIM  = 7'd8;
    localparam logic [KDIM_W-1:0] RST_KERNEL  = 4'd2;
    localparam logic [KDIM_W-1:0] RST_STRIDE  = 4'd2;

    // Remainder unit: one dividend bit per step, wide enough for rows and columns
    localparam int DIV_STEPS = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int DIVC_W    = $clog2(DIV_STEPS + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_WALK  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_PUSH  = 5'b10000
    } state_t;

    typedef struct packed {
        logic take;       // latch item, write line store, start remainder unit
        logic div_run;    // step remainder unit
        logic walk_run;   // issue one window read
        logic load_out;   // move window result into output register
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;   // remainders final
        logic hit;        // item closes a window
        logic walk_last;  // this read is the last of the window
        logic out_free;   // output register can take a result this cycle
    } dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mp2a_ram.sv -----
// ----------------------------------------------------------------------------
// mp2a_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2a_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mp2a_datapath.sv -----
// ----------------------------------------------------------------------------
// mp2a_datapath
// Config registers, stream counters, window remainder unit, window walk,
// line store, running max/argmax and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2a_datapath import mp2a_pkg::*; (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [CFG_IDX_W-1:0]           cfg_index,
    input  wire logic [CFG_DATA_W-1:0]          cfg_data,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_sample,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      m_max_value,
    output logic      [INDEX_W-1:0]             m_max_index,
    output logic      [IMG_W-1:0]               m_image_number,
    output logic                                m_last_window,
    input  wire dp_cmd_t                        cmd,
    output dp_status_t                          status
);

    localparam logic [DIM_W-1:0]  ROWS_LIM = DIM_W'(MAX_ROWS);
    localparam logic [DIM_W-1:0]  COLS_LIM = DIM_W'(MAX_COLS);
    localparam logic [KDIM_W-1:0] KERN_LIM = KDIM_W'(MAX_KERNEL);

    // Config registers
    logic [DIM_W-1:0]  in_rows_reg, in_cols_reg;
    logic [KDIM_W-1:0] kernel_rows_reg, kernel_cols_reg, stride_row_reg, stride_col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_rows_reg     <= RST_IN_DIM;
            in_cols_reg     <= RST_IN_DIM;
            kernel_rows_reg <= RST_KERNEL;
            kernel_cols_reg <= RST_KERNEL;
            stride_row_reg  <= RST_STRIDE;
            stride_col_reg  <= RST_STRIDE;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_IN_ROWS:     in_rows_reg     <= cfg_data;
                REG_IN_COLS:     in_cols_reg     <= cfg_data;
                REG_KERNEL_ROWS: kernel_rows_reg <= cfg_data[KDIM_W-1:0];
                REG_KERNEL_COLS: kernel_cols_reg <= cfg_data[KDIM_W-1:0];
                REG_STRIDE_ROW:  stride_row_reg  <= cfg_data[KDIM_W-1:0];
                REG_STRIDE_COL:  stride_col_reg  <= cfg_data[KDIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective (saturated) sizes
    logic [DIM_W-1:0]  rows_eff, cols_eff;
    logic [KDIM_W-1:0] kr_sat, kc_sat, kr_eff, kc_eff, sr_eff, sc_eff;

    always_comb begin
        rows_eff = (in_rows_reg == '0) ? DIM_W'(1)
                 : ((in_rows_reg > ROWS_LIM) ? ROWS_LIM : in_rows_reg);
        cols_eff = (in_cols_reg == '0) ? DIM_W'(1)
                 : ((in_cols_reg > COLS_LIM) ? COLS_LIM : in_cols_reg);
        kr_sat = (kernel_rows_reg == '0) ? KDIM_W'(1)
               : ((kernel_rows_reg > KERN_LIM) ? KERN_LIM : kernel_rows_reg);
        kc_sat = (kernel_cols_reg == '0) ? KDIM_W'(1)
               : ((kernel_cols_reg > KERN_LIM) ? KERN_LIM : kernel_cols_reg);
        // kernel no larger than the image
        kr_eff = (DIM_W'(kr_sat) > rows_eff) ? rows_eff[KDIM_W-1:0] : kr_sat;
        kc_eff = (DIM_W'(kc_sat) > cols_eff) ? cols_eff[KDIM_W-1:0] : kc_sat;
        sr_eff = (stride_row_reg == '0) ? KDIM_W'(1) : stride_row_reg;
        sc_eff = (stride_col_reg == '0) ? KDIM_W'(1) : stride_col_reg;
    end

    // Stream position of the incoming item
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic [COL_W-1:0] col_count_reg, col_count_next;
    logic [IMG_W-1:0] image_count_reg, image_count_next;

    logic [DIM_W-1:0] r_tmp, r_plus1, c_plus1;
    logic [ROW_W-1:0] r_cur;
    logic [COL_W-1:0] c_cur;

    always_comb begin
        // counters left out of range by a size change restart here
        if (DIM_W'(col_count_reg) >= cols_eff) begin
            c_cur = '0;
            r_tmp = DIM_W'(row_count_reg) + DIM_W'(1);
        end else begin
            c_cur = col_count_reg;
            r_tmp = DIM_W'(row_count_reg);
        end
        r_cur   = (r_tmp >= rows_eff) ? '0 : r_tmp[ROW_W-1:0];
        r_plus1 = DIM_W'(r_cur) + DIM_W'(1);
        c_plus1 = DIM_W'(c_cur) + DIM_W'(1);

        row_count_next   = r_cur;
        image_count_next = image_count_reg;
        if (c_plus1 >= cols_eff) begin
            col_count_next = '0;
            if (r_plus1 >= rows_eff) begin
                row_count_next   = '0;
                image_count_next = image_count_reg + IMG_W'(1);
            end else begin
                row_count_next = r_plus1[ROW_W-1:0];
            end
        end else begin
            col_count_next = c_plus1[COL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg   <= '0;
            col_count_reg   <= '0;
            image_count_reg <= '0;
        end else if (cmd.take) begin
            row_count_reg   <= row_count_next;
            col_count_reg   <= col_count_next;
            image_count_reg <= image_count_next;
        end
    end

    // Window origin and grid test inputs
    logic             rge, cge;
    logic [DIM_W-1:0] r0_full, c0_full;

    assign rge     = r_plus1 >= DIM_W'(kr_eff);
    assign cge     = c_plus1 >= DIM_W'(kc_eff);
    assign r0_full = r_plus1 - DIM_W'(kr_eff);
    assign c0_full = c_plus1 - DIM_W'(kc_eff);

    // Item registers
    logic                 rge_reg, cge_reg, last_reg;
    logic [ROW_W-1:0]     r0_reg;
    logic [COL_W-1:0]     c0_reg;
    logic [DIV_STEPS-1:0] dr_sh_reg, dc_sh_reg;
    logic [IMG_W-1:0]     img_cur_reg;

    // Remainder unit: restoring, one dividend bit per step, rows and columns
    logic [DIVC_W-1:0] div_cnt_reg;
    logic [KDIM_W-1:0] rem_r_reg, rem_c_reg, rem_r_next, rem_c_next;
    logic [KDIM_W:0]   rem_r_sh, rem_c_sh;
    logic              div_done;

    assign div_done = div_cnt_reg == DIVC_W'(DIV_STEPS);

    always_comb begin
        rem_r_sh   = {rem_r_reg, dr_sh_reg[DIV_STEPS-1]};
        rem_c_sh   = {rem_c_reg, dc_sh_reg[DIV_STEPS-1]};
        rem_r_next = (rem_r_sh >= (KDIM_W+1)'(sr_eff))
                   ? KDIM_W'(rem_r_sh - (KDIM_W+1)'(sr_eff)) : rem_r_sh[KDIM_W-1:0];
        rem_c_next = (rem_c_sh >= (KDIM_W+1)'(sc_eff))
                   ? KDIM_W'(rem_c_sh - (KDIM_W+1)'(sc_eff)) : rem_c_sh[KDIM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.take) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_run && !div_done) begin
            div_cnt_reg <= div_cnt_reg + DIVC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            rge_reg     <= rge;
            cge_reg     <= cge;
            r0_reg      <= r0_full[ROW_W-1:0];
            c0_reg      <= c0_full[COL_W-1:0];
            dr_sh_reg   <= DIV_STEPS'(r0_full[ROW_W-1:0]);
            dc_sh_reg   <= DIV_STEPS'(c0_full[COL_W-1:0]);
            rem_r_reg   <= '0;
            rem_c_reg   <= '0;
            img_cur_reg <= image_count_reg;
            // last window: no further grid origin fits in either direction
            last_reg    <= ((r_plus1 + DIM_W'(sr_eff)) > rows_eff)
                        && ((c_plus1 + DIM_W'(sc_eff)) > cols_eff);
        end else if (cmd.div_run && !div_done) begin
            dr_sh_reg <= {dr_sh_reg[DIV_STEPS-2:0], 1'b0};
            dc_sh_reg <= {dc_sh_reg[DIV_STEPS-2:0], 1'b0};
            rem_r_reg <= rem_r_next;
            rem_c_reg <= rem_c_next;
        end
    end

    // Window walk
    logic [KIDX_W-1:0] wi_reg, wj_reg;
    logic [ROW_W-1:0]  rr;
    logic [COL_W-1:0]  cc;
    logic              wj_end, walk_last;

    assign rr        = r0_reg + ROW_W'(wi_reg);
    assign cc        = c0_reg + COL_W'(wj_reg);
    assign wj_end    = KDIM_W'(wj_reg) == (kc_eff - KDIM_W'(1));
    assign walk_last = wj_end && (KDIM_W'(wi_reg) == (kr_eff - KDIM_W'(1)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wi_reg <= '0;
            wj_reg <= '0;
        end else if (cmd.take) begin
            wi_reg <= '0;
            wj_reg <= '0;
        end else if (cmd.walk_run) begin
            if (wj_end) begin
                wj_reg <= '0;
                wi_reg <= wi_reg + KIDX_W'(1);
            end else begin
                wj_reg <= wj_reg + KIDX_W'(1);
            end
        end
    end

    // Line store
    logic [SAMPLE_WIDTH-1:0] ram_rdata;

    mp2a_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (cmd.take),
        .waddr ({r_cur[LSEL_W-1:0], c_cur}),
        .wdata (s_sample),
        .re    (cmd.walk_run),
        .raddr ({rr[LSEL_W-1:0], cc}),
        .rdata (ram_rdata)
    );

    // Read pipeline tags and running max
    logic                           rd_valid_reg, first_d_reg;
    logic [ROW_W-1:0]               rr_d_reg;
    logic [COL_W-1:0]               cc_d_reg;
    logic signed [SAMPLE_WIDTH-1:0] best_reg;
    logic [INDEX_W-1:0]             best_idx_reg;
    logic [PROD_W-1:0]              cand_full;
    logic [INDEX_W-1:0]             cand_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.walk_run;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.walk_run) begin
            rr_d_reg    <= rr;
            cc_d_reg    <= cc;
            first_d_reg <= (wi_reg == '0) && (wj_reg == '0);
        end
    end

    assign cand_full = PROD_W'(rr_d_reg * cols_eff) + PROD_W'(cc_d_reg);
    assign cand_idx  = cand_full[INDEX_W-1:0];

    always_ff @(posedge aclk) begin
        // strict greater keeps the first maximum in row-major order
        if (rd_valid_reg && (first_d_reg || ($signed(ram_rdata) > best_reg))) begin
            best_reg     <= $signed(ram_rdata);
            best_idx_reg <= cand_idx;
        end
    end

    // Output register
    logic out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_max_value    <= best_reg;
            m_max_index    <= best_idx_reg;
            m_image_number <= img_cur_reg;
            m_last_window  <= last_reg;
        end
    end

    assign m_valid = out_valid_reg;

    always_comb begin
        status.div_done  = div_done;
        status.hit       = rge_reg && cge_reg && (rem_r_reg == '0) && (rem_c_reg == '0);
        status.walk_last = walk_last;
        status.out_free  = !out_valid_reg || m_ready;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mp2a_ctrl.sv -----
// ----------------------------------------------------------------------------
// mp2a_ctrl
// Sequencer: take item, grid test, window walk, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2a_ctrl import mp2a_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_run = 1'b1;
                if (status.div_done) begin
                    state_next = status.hit ? ST_WALK : ST_IDLE;
                end
            end
            ST_WALK: begin
                cmd.walk_run = 1'b1;
                if (status.walk_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last read lands in the running max
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/max_pool_2d_argmax.sv -----
// An item that closes no window passes the take cycle, the remainder steps and the
//   decision cycle, set by the bit-serial grid test, and is then done.
// An item that closes a window adds kernel_rows*kernel_cols line-store reads (one per
//   cycle, single read port), a drain step and the hand-off to the output register.
// No new item is taken until the last one is done, plus any wait of a result for m_ready.
// Reset (aresetn low, synchronous): counters and output valid cleared, config registers set to reset values.
// ----------------------------------------------------------------------------
// max_pool_2d_argmax
// Streaming 2-D max pooling with argmax over a raster-order sample stream.
// ----------------------------------------------------------------------------
`default_nettype none

module max_pool_2d_argmax import mp2a_pkg::*; (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration write port
    input  wire logic                           cfg_we,
    input  wire logic [CFG_IDX_W-1:0]           cfg_index,
    input  wire logic [CFG_DATA_W-1:0]          cfg_data,
    // Input samples
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_sample,
    // Window results
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      m_max_value,
    output logic      [INDEX_W-1:0]             m_max_index,
    output logic      [IMG_W-1:0]               m_image_number,
    output logic                                m_last_window
);

    // The controller sequences each item:
    //   IDLE  - ready; on accept the sample is written to the line store at
    //           row (mod MAX_KERNEL), column, and the counters advance.
    //   DIV   - bit-serial remainders of the window origin by the strides
    //           decide whether the item closes a window on the stride grid.
    //   WALK  - one line-store read per cycle over the window, row-major.
    //   DRAIN - last read data enters the running max.
    //   PUSH  - result goes to the output register once it is free.
    // The output register decouples the result side: a new item is taken
    // while an earlier result still waits for m_ready.
    // The line store is not cleared at reset; every read hits an entry that
    // the current stream has written.

    dp_cmd_t    cmd;
    dp_status_t status;

    mp2a_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mp2a_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_max_value    (m_max_value),
        .m_max_index    (m_max_index),
        .m_image_number (m_image_number),
        .m_last_window  (m_last_window),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/mp2a_checker.sv -----
// ----------------------------------------------------------------------------
// mp2a_checker
// Port-level checks for the pooling block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "max_pool_2d_argmax_macros.svh"

module mp2a_checker import mp2a_pkg::*; (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_valid,
    input wire logic                           s_ready,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire logic signed [SAMPLE_WIDTH-1:0] m_max_value,
    input wire logic      [INDEX_W-1:0]        m_max_index,
    input wire logic      [IMG_W-1:0]          m_image_number,
    input wire logic                           m_last_window
);

    // a stalled result keeps its value
    `MP2A_ASSERT_NEXT(a_out_hold, m_valid && !m_ready,
        m_valid && $stable(m_max_value) && $stable(m_max_index)
        && $stable(m_image_number) && $stable(m_last_window))

    // one item in work at a time
    `MP2A_ASSERT_NEXT(a_one_item, s_valid && s_ready, !s_ready)

    // a fresh result only comes out of a busy sequencer
    `MP2A_ASSERT_NOW(a_out_from_busy, $rose(m_valid), !$past(s_ready))

    // reset leaves the block empty and ready
    `MP2A_ASSERT_RST(a_reset_state, !aresetn, !m_valid && s_ready)

endmodule

bind max_pool_2d_argmax mp2a_checker u_checker (.*);

`default_nettype wire
